[hdl/prbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prbd_pkg;

  // Widths fixed by the stream format.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned CountW  = 15;
  localparam int unsigned SourceW = 16;
  localparam int unsigned RunW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;

  // Default largest row, in units.
  localparam int unsigned DefMaxRowUnits = 16384;

  // Result queue depth.
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegUnitIs16bit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRowUnits    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWidePrefix  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRowCount    = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StSrcShort = 2'd1;
  localparam logic [StatusW-1:0] StRowOver  = 2'd2;

  // Parser phases.
  typedef enum logic [5:0] {
    PhPrefix   = 6'b000001,
    PhPrefixLo = 6'b000010,
    PhControl  = 6'b000100,
    PhWordHi   = 6'b001000,
    PhByte     = 6'b010000,
    PhWordLo   = 6'b100000
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  count;
    logic               row_end;
    logic               image_end;
    logic [StatusW-1:0] status;
  } res_t;

  // Results produced by one accepted byte.
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

endpackage

`default_nettype wire

[hdl/packbits_row_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// PackBits row decoder. One packed stream byte is taken each cycle while
// full is low, and each byte yields zero, one or two runs. A parser
// classifies prefix, control and data bytes, and a four-entry result queue
// sits between it and the result ports, so full rises when fewer than two
// entries are free. Runs are queued when their byte is taken and reach
// the result ports once earlier runs are popped. An error run ends the
// image and the next byte is read as a new first prefix.
module packbits_row_decoder_unit import prbd_pkg::*; #(
  parameter int unsigned MAX_ROW_UNITS = DefMaxRowUnits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [ByteW-1:0]   in_byte_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [ValueW-1:0]       run_value_o,
  output logic [CountW-1:0]       run_count_o,
  output logic                    row_end_o,
  output logic                    image_end_o,
  output logic [StatusW-1:0]      status_o
);

  res_pair_t res;
  res_t      head;
  logic      room2;

  assign full = !room2;

  // Parser front end.
  prbd_front #(.MAX_ROW_UNITS(MAX_ROW_UNITS)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .byte_valid_i (push && room2),
    .byte_i       (in_byte_i),
    .res_o        (res)
  );

  // Result queue.
  prbd_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (res),
    .room2_o (room2),
    .rd_i    (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  assign run_value_o = head.value;
  assign run_count_o = head.count;
  assign row_end_o   = head.row_end;
  assign image_end_o = head.image_end;
  assign status_o    = head.status;

endmodule

`default_nettype wire

[hdl/prbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module prbd_front import prbd_pkg::*; #(
  parameter int unsigned MAX_ROW_UNITS = DefMaxRowUnits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               byte_valid_i,
  input  wire logic [ByteW-1:0]   byte_i,
  output res_pair_t               res_o
);

  localparam logic [CountW-1:0] MaxUnits = CountW'(MAX_ROW_UNITS);

  // Configuration registers.
  logic              unit16_q, wide_prefix_q;
  logic [CountW-1:0] row_units_q, row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit16_q      <= 1'b0;
      row_units_q   <= CountW'(1);
      wide_prefix_q <= 1'b0;
      row_count_q   <= CountW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegUnitIs16bit: unit16_q      <= cfg_data_i[0];
        RegRowUnits:    row_units_q   <= cfg_data_i;
        RegWidePrefix:  wide_prefix_q <= cfg_data_i[0];
        RegRowCount:    row_count_q   <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Parser state.
  phase_e             phase_q, phase_d;
  logic [SourceW-1:0] src_q, src_d;
  logic [CountW-1:0]  units_q, units_d;
  logic [RunW-1:0]    run_q, run_d;
  logic [ByteW-1:0]   high_q, high_d;
  logic [CountW-1:0]  rows_q, rows_d;
  logic               rep_q, rep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      src_q   <= '0;
      units_q <= '0;
      run_q   <= '0;
      high_q  <= '0;
      rows_q  <= '0;
      rep_q   <= 1'b0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      src_q   <= src_d;
      units_q <= units_d;
      run_q   <= run_d;
      high_q  <= high_d;
      rows_q  <= rows_d;
      rep_q   <= rep_d;
    end
  end

  // Byte classification and row bookkeeping.
  logic [CountW-1:0]  rows_lim, units_lim, end_units, cnt;
  logic [SourceW-1:0] src_dec, src_new;
  logic [8:0]         size;
  logic [9:0]         need;
  logic               last, end_req, unit_out;
  logic [ValueW-1:0]  val;

  always_comb begin
    phase_d = phase_q;
    src_d   = src_q;
    units_d = units_q;
    run_d   = run_q;
    high_d  = high_q;
    rows_d  = rows_q;
    rep_d   = rep_q;
    res_o   = '0;
    end_req = 1'b0;
    unit_out = 1'b0;
    size    = '0;
    need    = '0;
    cnt     = '0;
    val     = '0;
    src_new = '0;

    rows_lim  = (row_count_q == '0) ? CountW'(1) : row_count_q;
    last      = ({1'b0, rows_q} + 16'd1) >= {1'b0, rows_lim};
    units_lim = (row_units_q == '0) ? CountW'(1) :
                (row_units_q > MaxUnits) ? MaxUnits : row_units_q;
    src_dec   = (src_q != '0) ? src_q - SourceW'(1) : src_q;

    unique case (phase_q)
      PhPrefix, PhPrefixLo: begin
        if (phase_q == PhPrefix && wide_prefix_q) begin
          high_d  = byte_i;
          phase_d = PhPrefixLo;
        end else begin
          src_new = (phase_q == PhPrefixLo) ? {high_q, byte_i} : {8'd0, byte_i};
          src_d   = src_new;
          units_d = units_lim;
          high_d  = '0;
          phase_d = PhControl;
          end_req = (src_new == '0);
        end
      end
      PhControl: begin
        src_d = src_dec;
        if (byte_i == 8'h80) begin
          end_req = (src_dec == '0);
        end else begin
          rep_d = !(byte_i >= 8'd1 && byte_i <= 8'd127);
          if (!rep_d) begin
            size = {1'b0, byte_i} + 9'd1;
          end else begin
            size = (byte_i == 8'd0) ? 9'd1 : 9'd257 - {1'b0, byte_i};
          end
          if (rep_d) begin
            need = unit16_q ? 10'd2 : 10'd1;
          end else begin
            need = unit16_q ? {size, 1'b0} : {1'b0, size};
          end
          if ({6'd0, need} > src_dec) begin
            res_o.num  = 2'd1;
            res_o.res0 = '{value: '0, count: '0, row_end: 1'b1, image_end: 1'b1,
                           status: StSrcShort};
          end else if ({6'd0, size} > units_q) begin
            res_o.num  = 2'd1;
            res_o.res0 = '{value: '0, count: '0, row_end: 1'b1, image_end: 1'b1,
                           status: StRowOver};
          end else begin
            run_d   = size[RunW-1:0];
            high_d  = '0;
            phase_d = unit16_q ? PhWordHi : PhByte;
          end
        end
      end
      PhWordHi: begin
        src_d   = src_dec;
        high_d  = byte_i;
        phase_d = PhWordLo;
      end
      PhByte, PhWordLo: begin
        // A unit is complete.
        src_d    = src_dec;
        unit_out = 1'b1;
        val      = (phase_q == PhWordLo) ? {high_q, byte_i} : {8'd0, byte_i};
        cnt      = rep_q ? {7'd0, run_q} : CountW'(1);
        if (cnt > units_q) cnt = units_q;
        res_o.num  = 2'd1;
        res_o.res0 = '{value: val, count: cnt, row_end: 1'b0, image_end: 1'b0,
                       status: StOk};
        units_d = units_q - cnt;
        run_d   = (rep_q || run_q <= RunW'(1)) ? '0 : run_q - RunW'(1);
        high_d  = '0;
        if (run_d == '0) begin
          phase_d = PhControl;
          end_req = (src_dec == '0);
        end else begin
          phase_d = (phase_q == PhWordLo) ? PhWordHi : PhByte;
        end
      end
      default: ;
    endcase

    // An error clears everything back to the start of an image.
    if (res_o.num != 2'd0 && res_o.res0.status != StOk) begin
      phase_d = PhPrefix;
      src_d   = '0;
      units_d = '0;
      run_d   = '0;
      high_d  = '0;
      rows_d  = '0;
      rep_d   = 1'b0;
    end

    // Row end: mark the unit result or add a padding result.
    end_units = units_d;
    if (end_req) begin
      if (unit_out && end_units == '0) begin
        res_o.res0.row_end   = 1'b1;
        res_o.res0.image_end = last;
      end else if (unit_out) begin
        res_o.num  = 2'd2;
        res_o.res1 = '{value: '0, count: end_units, row_end: 1'b1, image_end: last,
                       status: StOk};
      end else begin
        res_o.num  = 2'd1;
        res_o.res0 = '{value: '0, count: end_units, row_end: 1'b1, image_end: last,
                       status: StOk};
      end
      rows_d  = last ? '0 : rows_q + CountW'(1);
      units_d = '0;
      run_d   = '0;
      high_d  = '0;
      phase_d = PhPrefix;
    end

    // Results are only offered for a byte that is actually taken.
    if (!byte_valid_i) res_o.num = 2'd0;
  end

endmodule

`default_nettype wire

[hdl/prbd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module prbd_queue import prbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  res_pair_t wr_i,
  output logic      room2_o,
  input  wire logic rd_i,
  output logic      empty_o,
  output res_t      head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  res_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop     = rd_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign room2_o = cnt_q <= CntW'(QueueDepth - 2);
  assign head_o  = mem_q[rd_q];

  // Entries take up to two beats a cycle from the parser.
  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) mem_q[wr_q] <= wr_i.res0;
    if (wr_i.num == 2'd2) mem_q[wr_q + PtrW'(1)] <= wr_i.res1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(wr_i.num);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(wr_i.num) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

[hdl/prbd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module prbd_checker import prbd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [CountW-1:0]  run_count_o,
  input wire logic               row_end_o,
  input wire logic               image_end_o,
  input wire logic [StatusW-1:0] status_o
);

  // An error beat closes the image and carries no units.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != StOk) |-> (row_end_o && image_end_o && run_count_o == '0))
    else $error("error beat malformed");

  // The image end is always a row end.
  a_img_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && image_end_o) |-> row_end_o)
    else $error("image end without row end");

  // A data run inside a row always writes at least one unit.
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !row_end_o) |-> (run_count_o != '0 && status_o == StOk))
    else $error("empty run inside a row");

  // A waiting beat is not withdrawn.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result lost while stalled");

endmodule

bind packbits_row_decoder_unit prbd_checker u_prbd_checker (
  .clk_i,
  .rst_ni,
  .empty,
  .pop,
  .run_count_o,
  .row_end_o,
  .image_end_o,
  .status_o
);

`default_nettype wire
